// ----- sv/ibst_pkg.sv -----
// ibst_pkg: shared types, constants and usage table for the image barrier state tracker
`timescale 1ns / 1ps
`default_nettype none

package ibst_pkg;

  localparam int RESOURCES = 64;
  localparam int ADDR_W    = (RESOURCES > 1) ? $clog2(RESOURCES) : 1;

  localparam int LAYOUT_W = 31;
  localparam int MASK_W   = 64;
  localparam int COUNT_W  = 32;
  localparam int FORMAT_W = 31;
  localparam int INDEX_W  = 6;
  localparam int USAGE_W  = 4;

  typedef enum logic {
    OP_ACCESS = 1'b0,
    OP_INIT   = 1'b1
  } op_t;

  typedef enum logic [USAGE_W-1:0] {
    USAGE_COLOR         = 4'd0,
    USAGE_DEPTH         = 4'd1,
    USAGE_SAMPLED       = 4'd2,
    USAGE_STORAGE_READ  = 4'd3,
    USAGE_STORAGE_WRITE = 4'd4,
    USAGE_XFER_SRC      = 4'd5,
    USAGE_XFER_DST      = 4'd6,
    USAGE_PRESENT       = 4'd7
  } usage_t;

  // image layout codes
  localparam logic [LAYOUT_W-1:0] LAYOUT_GENERAL     = 31'd1;
  localparam logic [LAYOUT_W-1:0] LAYOUT_COLOR_ATT   = 31'd2;
  localparam logic [LAYOUT_W-1:0] LAYOUT_SHADER_READ = 31'd5;
  localparam logic [LAYOUT_W-1:0] LAYOUT_XFER_SRC    = 31'd6;
  localparam logic [LAYOUT_W-1:0] LAYOUT_XFER_DST    = 31'd7;
  localparam logic [LAYOUT_W-1:0] LAYOUT_DEPTH_ATT   = 31'd1000241000;
  localparam logic [LAYOUT_W-1:0] LAYOUT_PRESENT_SRC = 31'd1000001002;

  // pipeline stage bits
  localparam logic [MASK_W-1:0] STG_FRAG_SHADER = 64'h0000_0000_0000_0080;
  localparam logic [MASK_W-1:0] STG_EARLY_FRAG  = 64'h0000_0000_0000_0100;
  localparam logic [MASK_W-1:0] STG_LATE_FRAG   = 64'h0000_0000_0000_0200;
  localparam logic [MASK_W-1:0] STG_COLOR_OUT   = 64'h0000_0000_0000_0400;
  localparam logic [MASK_W-1:0] STG_COMPUTE     = 64'h0000_0000_0000_0800;
  localparam logic [MASK_W-1:0] STG_BOTTOM      = 64'h0000_0000_0000_2000;
  localparam logic [MASK_W-1:0] STG_ALL_CMDS    = 64'h0000_0000_0001_0000;
  localparam logic [MASK_W-1:0] STG_COPY        = 64'h0000_0001_0000_0000;

  // access bits
  localparam logic [MASK_W-1:0] ACC_COLOR_READ    = 64'h0000_0000_0000_0080;
  localparam logic [MASK_W-1:0] ACC_COLOR_WRITE   = 64'h0000_0000_0000_0100;
  localparam logic [MASK_W-1:0] ACC_DEPTH_READ    = 64'h0000_0000_0000_0200;
  localparam logic [MASK_W-1:0] ACC_DEPTH_WRITE   = 64'h0000_0000_0000_0400;
  localparam logic [MASK_W-1:0] ACC_XFER_READ     = 64'h0000_0000_0000_0800;
  localparam logic [MASK_W-1:0] ACC_XFER_WRITE    = 64'h0000_0000_0000_1000;
  localparam logic [MASK_W-1:0] ACC_SAMPLED_READ  = 64'h0000_0001_0000_0000;
  localparam logic [MASK_W-1:0] ACC_STORAGE_READ  = 64'h0000_0002_0000_0000;
  localparam logic [MASK_W-1:0] ACC_STORAGE_WRITE = 64'h0000_0004_0000_0000;

  localparam logic [MASK_W-1:0] WRITE_MASK =
    ACC_COLOR_WRITE | ACC_DEPTH_WRITE | ACC_STORAGE_WRITE | ACC_XFER_WRITE;

  // depth formats
  localparam logic [FORMAT_W-1:0] FMT_D16_UNORM         = 31'd124;
  localparam logic [FORMAT_W-1:0] FMT_D32_SFLOAT        = 31'd126;
  localparam logic [FORMAT_W-1:0] FMT_D24_UNORM_S8_UINT = 31'd129;
  localparam logic [FORMAT_W-1:0] FMT_D32_SFLOAT_S8     = 31'd130;

  typedef struct packed {
    logic [LAYOUT_W-1:0] layout;
    logic [MASK_W-1:0]   stage;
    logic [MASK_W-1:0]   access;
  } usage_row_t;

  typedef struct packed {
    logic [LAYOUT_W-1:0] layout;
    logic [MASK_W-1:0]   stage;
    logic [MASK_W-1:0]   access;
    logic                depth;
  } entry_t;

  function automatic usage_row_t usage_lookup(input logic [USAGE_W-1:0] usage);
    usage_row_t row;
    case (usage)
      USAGE_COLOR:         row = '{LAYOUT_COLOR_ATT, STG_COLOR_OUT,
                                   ACC_COLOR_WRITE | ACC_COLOR_READ};
      USAGE_DEPTH:         row = '{LAYOUT_DEPTH_ATT, STG_EARLY_FRAG | STG_LATE_FRAG,
                                   ACC_DEPTH_WRITE | ACC_DEPTH_READ};
      USAGE_SAMPLED:       row = '{LAYOUT_SHADER_READ, STG_FRAG_SHADER | STG_COMPUTE,
                                   ACC_SAMPLED_READ};
      USAGE_STORAGE_READ:  row = '{LAYOUT_GENERAL, STG_COMPUTE, ACC_STORAGE_READ};
      USAGE_STORAGE_WRITE: row = '{LAYOUT_GENERAL, STG_COMPUTE,
                                   ACC_STORAGE_WRITE | ACC_STORAGE_READ};
      USAGE_XFER_SRC:      row = '{LAYOUT_XFER_SRC, STG_COPY, ACC_XFER_READ};
      USAGE_XFER_DST:      row = '{LAYOUT_XFER_DST, STG_COPY, ACC_XFER_WRITE};
      USAGE_PRESENT:       row = '{LAYOUT_PRESENT_SRC, STG_BOTTOM, '0};
      default:             row = '{LAYOUT_GENERAL, STG_ALL_CMDS, '0};
    endcase
    return row;
  endfunction

  function automatic logic format_is_depth(input logic [FORMAT_W-1:0] fmt);
    return (fmt == FMT_D16_UNORM) || (fmt == FMT_D32_SFLOAT) ||
           (fmt == FMT_D24_UNORM_S8_UINT) || (fmt == FMT_D32_SFLOAT_S8);
  endfunction

endpackage

`default_nettype wire

// ----- sv/image_barrier_state_tracker.sv -----
// image_barrier_state_tracker: per-resource layout/stage/access table and barrier decision
// a beat passes stage 1 (beat and table read) into the result registers (two stages)
// throughput: one beat per cycle unless out_stall holds a result; table read at accept, written at result edge
// a one-entry bypass of the last table write covers back-to-back beats on one resource
// reset: clears the stage valids, the bypass valid and the barrier count
// the resource table is not cleared; an entry holds garbage until its init beat
`timescale 1ns / 1ps
`default_nettype none

module image_barrier_state_tracker (
  input  wire logic                            clk,
  input  wire logic                            rst,

  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic                            op,
  input  wire logic [ibst_pkg::INDEX_W-1:0]    resource_index,
  input  wire logic [ibst_pkg::USAGE_W-1:0]    usage,
  input  wire logic [ibst_pkg::LAYOUT_W-1:0]   init_layout,
  input  wire logic [ibst_pkg::MASK_W-1:0]     init_stage,
  input  wire logic [ibst_pkg::MASK_W-1:0]     init_access,
  input  wire logic [ibst_pkg::FORMAT_W-1:0]   init_format,

  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic                                 barrier_needed,
  output logic [ibst_pkg::LAYOUT_W-1:0]        old_layout,
  output logic [ibst_pkg::LAYOUT_W-1:0]        new_layout,
  output logic [ibst_pkg::MASK_W-1:0]          src_stage,
  output logic [ibst_pkg::MASK_W-1:0]          src_access,
  output logic [ibst_pkg::MASK_W-1:0]          dst_stage,
  output logic [ibst_pkg::MASK_W-1:0]          dst_access,
  output logic                                 depth_aspect,
  output logic [ibst_pkg::COUNT_W-1:0]         barrier_total
);

  ibst_pkg::entry_t mem [ibst_pkg::RESOURCES];

  // stage 1: registered beat plus registered table read
  logic                              s1_valid;
  logic                              s1_op;
  logic [ibst_pkg::INDEX_W-1:0]      s1_index;
  logic [ibst_pkg::USAGE_W-1:0]      s1_usage;
  logic [ibst_pkg::LAYOUT_W-1:0]     s1_layout;
  logic [ibst_pkg::MASK_W-1:0]       s1_stage;
  logic [ibst_pkg::MASK_W-1:0]       s1_access;
  logic [ibst_pkg::FORMAT_W-1:0]     s1_format;
  ibst_pkg::entry_t                  rd_entry;

  // last table write, for read-after-write on the next beat
  logic                              fwd_valid;
  logic [ibst_pkg::ADDR_W-1:0]       fwd_addr;
  ibst_pkg::entry_t                  fwd_entry;

  logic [ibst_pkg::COUNT_W-1:0]      barrier_count;
  logic [ibst_pkg::COUNT_W-1:0]      barrier_count_next;

  logic                              advance;
  logic                              s1_load;
  logic                              s1_fire;
  logic [ibst_pkg::ADDR_W-1:0]       in_addr;
  logic [ibst_pkg::ADDR_W-1:0]       s1_addr;
  logic                              s1_in_range;
  ibst_pkg::entry_t                  cur;
  ibst_pkg::usage_row_t              row;
  logic                              need;
  logic                              wr_en;
  ibst_pkg::entry_t                  wr_entry;
  ibst_pkg::entry_t                  res_old;
  ibst_pkg::usage_row_t              res_new;
  logic                              res_need;

  assign advance  = !out_valid || !out_stall;
  assign in_stall = s1_valid && !advance;
  assign s1_load  = in_valid && !in_stall;
  assign s1_fire  = s1_valid && advance;

  assign in_addr     = ibst_pkg::ADDR_W'(resource_index);
  assign s1_addr     = ibst_pkg::ADDR_W'(s1_index);
  assign s1_in_range = 32'(s1_index) < 32'(ibst_pkg::RESOURCES);

  always_comb begin
    cur = (fwd_valid && (fwd_addr == s1_addr)) ? fwd_entry : rd_entry;
    row = ibst_pkg::usage_lookup(s1_usage);
    need = (s1_op == ibst_pkg::OP_ACCESS) && s1_in_range &&
           ((cur.layout != row.layout) ||
            (((cur.access | row.access) & ibst_pkg::WRITE_MASK) != '0));

    if (s1_op == ibst_pkg::OP_INIT) begin
      wr_entry = '{s1_layout, s1_stage, s1_access, ibst_pkg::format_is_depth(s1_format)};
      wr_en    = s1_fire && s1_in_range;
    end else begin
      // depth flag is carried over unchanged on an access
      wr_entry = '{row.layout, row.stage, row.access, cur.depth};
      wr_en    = s1_fire && need;
    end

    barrier_count_next = barrier_count + ibst_pkg::COUNT_W'(need);

    if (!s1_in_range) begin
      res_old  = '0;
      res_new  = '0;
      res_need = 1'b0;
    end else if (s1_op == ibst_pkg::OP_INIT) begin
      res_old  = wr_entry;
      res_new  = '{s1_layout, s1_stage, s1_access};
      res_need = 1'b0;
    end else begin
      res_old  = cur;
      res_new  = row;
      res_need = need;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[s1_addr] <= wr_entry;
    end
    if (s1_load) begin
      rd_entry <= mem[in_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      out_valid     <= 1'b0;
      fwd_valid     <= 1'b0;
      barrier_count <= '0;
    end else begin
      if (s1_load) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= s1_valid;
      end
      if (wr_en) begin
        fwd_valid <= 1'b1;
      end
      if (s1_fire) begin
        barrier_count <= barrier_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_op     <= op;
      s1_index  <= resource_index;
      s1_usage  <= usage;
      s1_layout <= init_layout;
      s1_stage  <= init_stage;
      s1_access <= init_access;
      s1_format <= init_format;
    end
    if (wr_en) begin
      fwd_addr  <= s1_addr;
      fwd_entry <= wr_entry;
    end
    if (s1_fire) begin
      barrier_needed <= res_need;
      old_layout     <= res_old.layout;
      src_stage      <= res_old.stage;
      src_access     <= res_old.access;
      depth_aspect   <= res_old.depth;
      new_layout     <= res_new.layout;
      dst_stage      <= res_new.stage;
      dst_access     <= res_new.access;
      barrier_total  <= barrier_count_next;
    end
  end

  // a held result always shows the live barrier count
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (barrier_total == barrier_count))
    else $error("barrier_total out of step with counter");

  // the input side stalls only behind an occupied first stage
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid))
    else $error("input stalled with a free pipeline");

  // a beat leaving stage 1 lands in the result register
  assert property (@(posedge clk) disable iff (rst)
    s1_fire |=> out_valid)
    else $error("result beat lost");

  // the counter moves by one only when a barrier beat is produced
  assert property (@(posedge clk) disable iff (rst)
    (barrier_count != $past(barrier_count)) |->
      (out_valid && barrier_needed && (barrier_count == $past(barrier_count) + 32'd1)))
    else $error("barrier counter moved without a barrier");

endmodule

`default_nettype wire
